// File: rtl/multiset_bag_store_macros.svh
// Assertion macros for the multiset bag store.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MULTISET_BAG_STORE_MACROS_SVH
`define MULTISET_BAG_STORE_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MSB_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("multiset_bag_store: assertion failed");
// Condition in one cycle implies a condition in the next.
`define MSB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("multiset_bag_store: sequence assertion failed");
`else
`define MSB_ASSERT(label, clk, rstn, prop)
`define MSB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/msbag_pkg.sv
// Shared types and constants for the multiset bag store.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package msbag_pkg;

  localparam int CAPACITY   = 64;
  localparam int ITEM_WIDTH = 16;
  localparam int VALUE_W    = 16;                      // width of the value port
  localparam int SIZE_W     = 7;                       // width of count ports
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_LAST,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic add_wr;
    logic scan;
    logic fetch_last;
    logic move;
    logic clear;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t op;
    logic scan_done;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

// File: rtl/multiset_bag_store.sv
// Multiset bag store: a fixed-capacity unordered collection of values.
// Usage:
//   Requests arrive on in_valid/in_stall with in_command (add, remove,
//   query, clear) and in_item_value. One request is in progress at a time;
//   in_stall is high from acceptance until the result is loaded.
//   Each request yields one result on out_valid/out_stall: out_accepted,
//   out_match_count, out_bag_size and out_bag_empty after the operation.
//   Add and clear need no scan. A query scans every stored entry; a remove
//   scans until its first match (or to the end on a miss). The scan walks
//   the entry memory one entry a cycle with one comparator. The next
//   request is taken the cycle after a result is loaded, so a request is
//   not taken before the one in progress is done.
//   Reset (rst_n low, synchronous) empties the store and drops any pending
//   result; entry contents are not cleared and need no sweep.
//   A stalled result holds in the output register; the next request can be
//   accepted and worked on meanwhile but waits to publish until it is taken.
// Depends on msbag_pkg, msbag_ctrl, msbag_dp and the assertion macro header.
`timescale 1ns / 1ps
`include "multiset_bag_store_macros.svh"

module multiset_bag_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [msbag_pkg::VALUE_W-1:0] in_item_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_accepted,
  output logic [msbag_pkg::SIZE_W-1:0]  out_match_count,
  output logic [msbag_pkg::SIZE_W-1:0]  out_bag_size,
  output logic                          out_bag_empty
);
  import msbag_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  msbag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  msbag_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_item_value   (in_item_value),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_match_count (out_match_count),
    .out_bag_size    (out_bag_size),
    .out_bag_empty   (out_bag_empty)
  );

  `MSB_ASSERT(a_rise_from_publish, clk, rst_n, $rose(out_valid) |-> $past(dp_cmd.publish))
  `MSB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `MSB_ASSERT(a_empty_matches_size, clk, rst_n, out_valid |-> (out_bag_empty == (out_bag_size == '0)))
  `MSB_ASSERT(a_count_implies_accept, clk, rst_n, (out_valid && out_match_count != '0) |-> out_accepted)

endmodule

// File: rtl/msbag_ctrl.sv
// Sequencer for the multiset bag store: walks each request through its steps.
// Depends on msbag_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module msbag_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  msbag_pkg::dp_sts_t sts,
  output msbag_pkg::dp_cmd_t cmd
);
  import msbag_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts.op)
          CMD_ADD, CMD_CLEAR:    state_nxt = ST_DONE;
          CMD_REMOVE, CMD_QUERY: state_nxt = ST_SCAN;
        endcase
      end
      ST_SCAN: begin
        if (sts.op == CMD_REMOVE && sts.hit) state_nxt = ST_LAST;
        else if (sts.scan_done)             state_nxt = ST_DONE;
      end
      ST_LAST:     state_nxt = ST_MOVE;
      ST_MOVE:     state_nxt = ST_DONE;
      ST_DONE:     if (sts.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:     cmd.capture = in_valid;
      ST_DISPATCH: begin
        cmd.add_wr = (sts.op == CMD_ADD);
        cmd.clear  = (sts.op == CMD_CLEAR);
      end
      ST_SCAN:     cmd.scan       = 1'b1;
      ST_LAST:     cmd.fetch_last = 1'b1;
      ST_MOVE:     cmd.move       = 1'b1;
      ST_DONE:     cmd.publish    = sts.out_free;
      default:     cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/msbag_dp.sv
// Datapath for the multiset bag store: entry memory, count, scan pipeline
// and result register. Depends on msbag_pkg; commanded by msbag_ctrl.
`timescale 1ns / 1ps

module msbag_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_command,
  input  logic [msbag_pkg::VALUE_W-1:0]   in_item_value,
  input  msbag_pkg::dp_cmd_t              cmd,
  output msbag_pkg::dp_sts_t              sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_accepted,
  output logic [msbag_pkg::SIZE_W-1:0]    out_match_count,
  output logic [msbag_pkg::SIZE_W-1:0]    out_bag_size,
  output logic                            out_bag_empty
);
  import msbag_pkg::*;

  logic [ITEM_WIDTH-1:0] mem [CAPACITY];

  cmd_t                  op_r,      op_nxt;
  logic [ITEM_WIDTH-1:0] val_r,     val_nxt;
  logic [CNT_W-1:0]      count_r,   count_nxt;
  logic [CNT_W-1:0]      idx_r,     idx_nxt;
  logic [CNT_W-1:0]      hits_r,    hits_nxt;
  logic [IDX_W-1:0]      hit_pos_r, hit_pos_nxt;
  logic [IDX_W-1:0]      rd_pos_r,  rd_pos_nxt;
  logic                  rd_vld_r,  rd_vld_nxt;
  logic                  acc_r,     acc_nxt;
  logic [ITEM_WIDTH-1:0] rdata_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_acc_r;
  logic [SIZE_W-1:0]     out_match_r, out_size_r;
  logic                  out_empty_r;

  logic                  full, eq, issue, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr, last_idx;
  logic [ITEM_WIDTH-1:0] wr_data;
  logic [CNT_W-1:0]      count_dec;

  always_comb begin
    full      = (count_r == CNT_W'(CAPACITY));
    eq        = rd_vld_r && (rdata_r == val_r);
    issue     = cmd.scan && (idx_r < count_r);
    count_dec = count_r - CNT_W'(1);
    last_idx  = count_dec[IDX_W-1:0];
    rd_addr   = cmd.fetch_last ? last_idx : idx_r[IDX_W-1:0];
    wr_en     = (cmd.add_wr && !full) || cmd.move;
    wr_addr   = cmd.move ? hit_pos_r : count_r[IDX_W-1:0];
    wr_data   = cmd.move ? rdata_r : val_r;
  end

  always_comb begin
    op_nxt      = op_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    hits_nxt    = hits_r;
    hit_pos_nxt = hit_pos_r;
    acc_nxt     = acc_r;
    rd_vld_nxt  = issue;
    rd_pos_nxt  = idx_r[IDX_W-1:0];

    if (cmd.capture) begin
      op_nxt   = cmd_t'(in_command);
      val_nxt  = in_item_value[ITEM_WIDTH-1:0];
      idx_nxt  = '0;
      hits_nxt = '0;
      acc_nxt  = 1'b0;
    end
    if (cmd.add_wr) begin
      acc_nxt = !full;
      if (!full) count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.clear) count_nxt = '0;
    if (cmd.scan) begin
      if (issue) idx_nxt = idx_r + CNT_W'(1);
      if (eq) begin
        hits_nxt = hits_r + CNT_W'(1);
        acc_nxt  = 1'b1;
        // keep the first match only
        if (hits_r == '0) hit_pos_nxt = rd_pos_r;
      end
    end
    if (cmd.move) count_nxt = count_dec;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish)     out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    hits_r    <= hits_nxt;
    hit_pos_r <= hit_pos_nxt;
    rd_pos_r  <= rd_pos_nxt;
    acc_r     <= acc_nxt;
    if (cmd.publish) begin
      out_acc_r   <= acc_r;
      out_match_r <= (op_r == CMD_QUERY) ? SIZE_W'(hits_r) : '0;
      out_size_r  <= SIZE_W'(count_r);
      out_empty_r <= (count_r == '0);
    end
  end

  always_comb begin
    sts.op        = op_r;
    sts.scan_done = (idx_r == count_r) && !rd_vld_r;
    sts.hit       = eq;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_acc_r;
  assign out_match_count = out_match_r;
  assign out_bag_size    = out_size_r;
  assign out_bag_empty   = out_empty_r;

endmodule

// File: verif/msbag_tb_pkg.sv
// Scoreboard for the multiset bag store: predicts one result per request.
// Keeps its own copy of the bag and a FIFO of expected results.
// Depends on msbag_pkg for the command codes and widths.
`timescale 1ns / 1ps

package msbag_tb_pkg;
  import msbag_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [SIZE_W-1:0] match_count;
    logic [SIZE_W-1:0] bag_size;
    logic              bag_empty;
  } bag_result_t;

  class bag_scoreboard;
    logic [VALUE_W-1:0] entries [CAPACITY];
    int unsigned        n_entries;
    bag_result_t        expected_q [$];
    int unsigned        mismatches;

    function new();
      n_entries  = 0;
      mismatches = 0;
      expected_q.delete();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Any value currently held in the bag; caller makes sure it is not empty.
    function logic [VALUE_W-1:0] stored_value();
      return entries[$urandom_range(n_entries - 1)];
    endfunction

    // Apply an accepted request to the predicted bag and queue its result.
    function void note_request(cmd_t cmd, logic [VALUE_W-1:0] value);
      bag_result_t res;
      int unsigned idx;
      int unsigned hits;
      logic        found;
      res   = '0;
      hits  = 0;
      found = 1'b0;
      case (cmd)
        CMD_ADD: begin
          if (n_entries < CAPACITY) begin
            entries[n_entries] = value;
            n_entries++;
            res.accepted = 1'b1;
          end
        end
        CMD_REMOVE: begin
          for (idx = 0; idx < n_entries; idx++) begin
            if (!found && entries[idx] == value) begin
              found = 1'b1;
              // move the last entry into the hole
              n_entries--;
              entries[idx] = entries[n_entries];
            end
          end
          res.accepted = found;
        end
        CMD_QUERY: begin
          for (idx = 0; idx < n_entries; idx++)
            if (entries[idx] == value) hits++;
          res.accepted    = (hits > 0);
          res.match_count = hits[SIZE_W-1:0];
        end
        default: begin
          n_entries = 0;
        end
      endcase
      res.bag_size  = n_entries[SIZE_W-1:0];
      res.bag_empty = (n_entries == 0);
      expected_q.insert(expected_q.size(), res);
    endfunction

    function void log_mismatch(string field, int unsigned exp_v, int unsigned act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("MISMATCH %s: expected %0d actual %0d", field, exp_v, act_v);
    endfunction

    function void check_result(bag_result_t act);
      bag_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("MISMATCH: result with no request pending (size %0d)", act.bag_size);
        return;
      end
      exp_r = expected_q.pop_front();
      if (act.accepted !== exp_r.accepted)
        log_mismatch("accepted", 32'(exp_r.accepted), 32'(act.accepted));
      if (act.match_count !== exp_r.match_count)
        log_mismatch("match_count", 32'(exp_r.match_count), 32'(act.match_count));
      if (act.bag_size !== exp_r.bag_size)
        log_mismatch("bag_size", 32'(exp_r.bag_size), 32'(act.bag_size));
      if (act.bag_empty !== exp_r.bag_empty)
        log_mismatch("bag_empty", 32'(exp_r.bag_empty), 32'(act.bag_empty));
    endfunction
  endclass

endpackage

// File: verif/tb_top.sv
// Top-level testbench for multiset_bag_store: directed and random requests
// under several idle/stall mixes, checked against the bag scoreboard.
// Depends on msbag_pkg, msbag_tb_pkg and the multiset_bag_store RTL.
`timescale 1ns / 1ps

module tb_top;
  import msbag_pkg::*;
  import msbag_tb_pkg::*;

  localparam int POOL_N = 8;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  cmd_t               in_command;
  logic [VALUE_W-1:0] in_item_value;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_accepted;
  logic [SIZE_W-1:0]  out_match_count;
  logic [SIZE_W-1:0]  out_bag_size;
  logic               out_bag_empty;

  int unsigned        sender_idle_pct = 0;
  int unsigned        recv_stall_pct  = 0;
  int unsigned        requests_sent   = 0;
  logic [VALUE_W-1:0] value_pool [POOL_N];

  bag_scoreboard      sb;

  multiset_bag_store u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accepted    (out_accepted),
    .out_match_count (out_match_count),
    .out_bag_size    (out_bag_size),
    .out_bag_empty   (out_bag_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_accepted, out_match_count, out_bag_size, out_bag_empty});
  end

  // Present one request, hold it until taken, then record it.
  task automatic issue(cmd_t cmd, logic [VALUE_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_item_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, value);
    requests_sent++;
  endtask

  // Mostly values from a small pool so that duplicates and hits are common.
  function automatic logic [VALUE_W-1:0] pool_value();
    if ($urandom_range(9) == 0) return VALUE_W'($urandom_range(16'hFFFF));
    return value_pool[$urandom_range(POOL_N - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] likely_hit();
    if (sb.n_entries > 0 && $urandom_range(9) < 8) return sb.stored_value();
    return pool_value();
  endfunction

  task automatic fill_bag();
    while (sb.n_entries < CAPACITY) issue(CMD_ADD, pool_value());
    repeat ($urandom_range(1, 3)) issue(CMD_ADD, pool_value());
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned n_requests);
    int unsigned stop_at;
    int unsigned kind;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    stop_at         = requests_sent + n_requests;
    foreach (value_pool[k]) value_pool[k] = VALUE_W'($urandom_range(16'hFFFF));
    issue(CMD_CLEAR, VALUE_W'($urandom_range(16'hFFFF)));
    fill_bag();
    while (requests_sent < stop_at) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2: repeat ($urandom_range(3, 12)) issue(CMD_ADD, pool_value());
        3:       fill_bag();
        4, 5:    repeat ($urandom_range(2, 12)) issue(CMD_REMOVE, likely_hit());
        6, 7: begin
          repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(1)) issue(CMD_QUERY, likely_hit());
            else issue(CMD_QUERY, pool_value());
          end
        end
        8: begin
          // noise: any command, any value
          repeat ($urandom_range(3, 10))
            issue(cmd_t'($urandom_range(3)), VALUE_W'($urandom_range(16'hFFFF)));
        end
        default: begin
          issue(CMD_CLEAR, VALUE_W'($urandom_range(16'hFFFF)));
          repeat ($urandom_range(0, 4)) issue(CMD_ADD, pool_value());
        end
      endcase
    end
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_ADD;
    in_item_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty-bag corner cases
    issue(CMD_QUERY,  16'h0000);
    issue(CMD_REMOVE, 16'h0000);
    issue(CMD_CLEAR,  16'hFFFF);
    // duplicates, first-match remove with last-entry move
    issue(CMD_ADD,    16'h0000);
    issue(CMD_ADD,    16'hFFFF);
    issue(CMD_ADD,    16'hA5A5);
    issue(CMD_ADD,    16'hFFFF);
    issue(CMD_QUERY,  16'hFFFF);
    issue(CMD_QUERY,  16'h0000);
    issue(CMD_REMOVE, 16'hFFFF);
    issue(CMD_QUERY,  16'hFFFF);
    issue(CMD_REMOVE, 16'h1234);
    // remove of the entry in the last slot
    issue(CMD_ADD,    16'h5A5A);
    issue(CMD_REMOVE, 16'h5A5A);
    issue(CMD_QUERY,  16'h5A5A);
    issue(CMD_REMOVE, 16'h0000);
    issue(CMD_QUERY,  16'hA5A5);
    issue(CMD_CLEAR,  16'h8001);
    issue(CMD_ADD,    16'h0001);
    issue(CMD_QUERY,  16'h0001);
    issue(CMD_REMOVE, 16'h0001);
    issue(CMD_QUERY,  16'hFFFF);

    // each phase starts by filling past capacity
    run_phase(0,  0,  132);
    run_phase(86, 0,  132);
    run_phase(0,  86, 132);
    run_phase(13, 13, 132);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray result after the last one
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/msbag_pkg.sv
rtl/msbag_ctrl.sv
rtl/msbag_dp.sv
rtl/multiset_bag_store.sv
verif/msbag_tb_pkg.sv
verif/tb_top.sv
